>>> sv/hvps_pkg.sv
// Shared types and constants for the HV precharge sequencer.
// Request and result payloads, configuration set, stage and register codes.
// No dependencies.
`timescale 1ns / 1ps

package hvps_pkg;

  // Stage codes
  localparam logic [2:0] STG_SAFETY = 3'd0;
  localparam logic [2:0] STG_ENABLE = 3'd1;
  localparam logic [2:0] STG_THRESH = 3'd2;
  localparam logic [2:0] STG_SETTLE = 3'd3;
  localparam logic [2:0] STG_DONE   = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BELOW_HOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 3'd5;

  // Configuration reset values
  localparam logic [15:0] RST_SENSE_HIGH   = 16'd2800;
  localparam logic [15:0] RST_THR_OFFSET   = 16'd328;
  localparam logic [15:0] RST_THR_GAIN     = 16'd46478;
  localparam logic [15:0] RST_SAFETY_DELAY = 16'd3000;
  localparam logic [15:0] RST_BELOW_HOLD   = 16'd50;
  localparam logic [15:0] RST_SETTLE       = 16'd250;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] pack_volts;
    logic        ext_fault;
    logic [15:0] sense_mv;
    logic [15:0] hall_mv;
  } in_req_t;

  typedef struct packed {
    logic        main_on;
    logic        precharge_on;
    logic [2:0]  stage_code;
    logic [15:0] threshold_mv;
    logic        contactor_high;
    logic        contactor_fault;
  } out_res_t;

  typedef struct packed {
    logic [15:0] sense_high_mv;
    logic [15:0] thresh_offset_mv;
    logic [15:0] thresh_gain_q16;
    logic [15:0] safety_delay_ms;
    logic [15:0] below_hold_ms;
    logic [15:0] settle_ms;
  } cfg_t;

  // Pre-computed request terms handed to the sequencer
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] hall_mv;
    logic        ext_fault;
    logic        pack_nz;
    logic        high;
    logic [31:0] gain_prod;
  } calc_t;

endpackage

>>> sv/hvps_calc.sv
// Front-end arithmetic for one request: gain product and contactor sense compare.
// Uses hvps_pkg types; purely combinational.
`timescale 1ns / 1ps

module hvps_calc (
  input  hvps_pkg::cfg_t    cfg,
  input  hvps_pkg::in_req_t req,
  output hvps_pkg::calc_t   calc
);

  // Multiply gain by pack voltage, compare sense level
  always_comb begin
    calc.now_ms    = req.now_ms;
    calc.hall_mv   = req.hall_mv;
    calc.ext_fault = req.ext_fault;
    calc.pack_nz   = (req.pack_volts != 16'd0);
    calc.high      = (req.sense_mv > cfg.sense_high_mv);
    calc.gain_prod = 32'(cfg.thresh_gain_q16) * 32'(req.pack_volts);
  end

endmodule

>>> sv/hvps_seq.sv
// Stage sequencer: threshold, fault latch, stage cascade and relay enables.
// Uses hvps_pkg types and stage codes; state advances once per request.
`timescale 1ns / 1ps

module hvps_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  hvps_pkg::cfg_t     cfg,
  input  hvps_pkg::calc_t    calc,
  output hvps_pkg::out_res_t res
);

  logic [2:0]  stage_r, stage_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic [31:0] bstart_r, bstart_nxt;
  logic        btiming_r, btiming_nxt;
  logic        drop_r, drop_nxt;
  logic        main_r, main_nxt;
  logic        pre_r, pre_nxt;
  logic [15:0] thr;

  // Saturating threshold: offset plus upper half of gain product
  always_comb begin
    logic [16:0] sum;
    sum = {1'b0, cfg.thresh_offset_mv} + {1'b0, calc.gain_prod[31:16]};
    thr = sum[16] ? 16'hFFFF : sum[15:0];
  end

  // Walk the stages for this request; several may pass in one request
  always_comb begin
    logic below;
    below       = (calc.hall_mv < thr);
    stage_nxt   = stage_r;
    entry_nxt   = entry_r;
    bstart_nxt  = bstart_r;
    btiming_nxt = btiming_r;
    main_nxt    = main_r;
    pre_nxt     = pre_r;
    drop_nxt    = drop_r;
    if (!calc.high && stage_r != hvps_pkg::STG_SAFETY && stage_r != hvps_pkg::STG_ENABLE) begin
      drop_nxt = 1'b1;
    end
    if (drop_nxt || calc.ext_fault) begin
      main_nxt    = 1'b0;
      pre_nxt     = 1'b0;
      btiming_nxt = 1'b0;
      stage_nxt   = hvps_pkg::STG_SAFETY;
      entry_nxt   = calc.now_ms;
    end else begin
      if (stage_nxt == hvps_pkg::STG_SAFETY) begin
        main_nxt = 1'b0;
        pre_nxt  = 1'b1;
        if ((calc.now_ms - entry_nxt) >= {16'd0, cfg.safety_delay_ms}) begin
          stage_nxt = hvps_pkg::STG_ENABLE;
          entry_nxt = calc.now_ms;
        end
      end
      if (stage_nxt == hvps_pkg::STG_ENABLE) begin
        if (calc.high && calc.pack_nz) begin
          btiming_nxt = 1'b0;
          stage_nxt   = hvps_pkg::STG_THRESH;
          entry_nxt   = calc.now_ms;
        end
      end
      if (stage_nxt == hvps_pkg::STG_THRESH) begin
        if (below) begin
          if (!btiming_nxt) begin
            btiming_nxt = 1'b1;
            bstart_nxt  = calc.now_ms;
          end
        end else begin
          btiming_nxt = 1'b0;
        end
        if (btiming_nxt && (calc.now_ms - bstart_nxt) >= {16'd0, cfg.below_hold_ms}) begin
          main_nxt    = 1'b1;
          btiming_nxt = 1'b0;
          stage_nxt   = hvps_pkg::STG_SETTLE;
          entry_nxt   = calc.now_ms;
        end
      end
      if (stage_nxt == hvps_pkg::STG_SETTLE) begin
        main_nxt = 1'b1;
        if ((calc.now_ms - entry_nxt) >= {16'd0, cfg.settle_ms}) begin
          pre_nxt   = 1'b0;
          stage_nxt = hvps_pkg::STG_DONE;
        end
      end
      if (stage_nxt == hvps_pkg::STG_DONE) begin
        main_nxt = 1'b1;
        pre_nxt  = 1'b0;
      end
    end
  end

  // Commit state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= hvps_pkg::STG_SAFETY;
      entry_r   <= 32'd0;
      bstart_r  <= 32'd0;
      btiming_r <= 1'b0;
      drop_r    <= 1'b0;
      main_r    <= 1'b0;
      pre_r     <= 1'b1;
    end else if (adv) begin
      stage_r   <= stage_nxt;
      entry_r   <= entry_nxt;
      bstart_r  <= bstart_nxt;
      btiming_r <= btiming_nxt;
      drop_r    <= drop_nxt;
      main_r    <= main_nxt;
      pre_r     <= pre_nxt;
    end
  end

  // Result for this request
  always_comb begin
    res.main_on         = main_nxt;
    res.precharge_on    = pre_nxt;
    res.stage_code      = stage_nxt;
    res.threshold_mv    = thr;
    res.contactor_high  = calc.high;
    res.contactor_fault = drop_nxt;
  end

endmodule

>>> sv/hv_precharge_sequencer_unit.sv
// Top level of the HV precharge sequencer: config registers, request pipeline.
// Depends on hvps_pkg, hvps_calc and hvps_seq.
`timescale 1ns / 1ps

// Usage:
//   Request channel in_valid / in_stall / in_req carries one control call
//   (timestamp, pack volts, external fault, sense and Hall voltages).
//   Result channel out_valid / out_stall / out_res returns one result per
//   request: relay enables, stage, Hall threshold, sense flag, latched fault.
//   Config port cfg_we / cfg_idx / cfg_wdata writes one register per cycle;
//   write only while no request is in flight. Unknown indexes are ignored.
//   A request passes the input register, the multiply register and the
//   sequencer into the result register.
//   Throughput: one request per cycle while the result side is not stalled,
//   with the sequencer state updated as each request enters the result register.
//   Reset (rst_n low, synchronous) restores the default register values,
//   puts the sequencer in the safety-delay stage with precharge closed and
//   empties the pipeline. Timestamps are taken to start at zero.
//   While out_stall is high the pipeline fills its empty stages and then
//   raises in_stall; the waiting result holds steady.

module hv_precharge_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hvps_pkg::in_req_t                in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hvps_pkg::out_res_t               out_res,
  input  logic                             cfg_we,
  input  logic [hvps_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [15:0]                      cfg_wdata
);

  hvps_pkg::cfg_t     cfg_r;
  hvps_pkg::in_req_t  s1_r;
  logic               s1_v_r;
  hvps_pkg::calc_t    s2_r;
  hvps_pkg::calc_t    calc;
  logic               s2_v_r;
  hvps_pkg::out_res_t out_r;
  hvps_pkg::out_res_t res;
  logic               out_v_r;
  logic               out_rdy, s2_rdy, s1_rdy, s2_adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sense_high_mv    <= hvps_pkg::RST_SENSE_HIGH;
      cfg_r.thresh_offset_mv <= hvps_pkg::RST_THR_OFFSET;
      cfg_r.thresh_gain_q16  <= hvps_pkg::RST_THR_GAIN;
      cfg_r.safety_delay_ms  <= hvps_pkg::RST_SAFETY_DELAY;
      cfg_r.below_hold_ms    <= hvps_pkg::RST_BELOW_HOLD;
      cfg_r.settle_ms        <= hvps_pkg::RST_SETTLE;
    end else if (cfg_we) begin
      case (cfg_idx)
        hvps_pkg::REG_SENSE_HIGH:   cfg_r.sense_high_mv    <= cfg_wdata;
        hvps_pkg::REG_THR_OFFSET:   cfg_r.thresh_offset_mv <= cfg_wdata;
        hvps_pkg::REG_THR_GAIN:     cfg_r.thresh_gain_q16  <= cfg_wdata;
        hvps_pkg::REG_SAFETY_DELAY: cfg_r.safety_delay_ms  <= cfg_wdata;
        hvps_pkg::REG_BELOW_HOLD:   cfg_r.below_hold_ms    <= cfg_wdata;
        hvps_pkg::REG_SETTLE:       cfg_r.settle_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage readiness, back to front
  assign out_rdy  = !out_v_r || !out_stall;
  assign s2_rdy   = !s2_v_r || out_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign s2_adv   = s2_v_r && out_rdy;
  assign in_stall = !s1_rdy;

  hvps_calc u_calc (
    .cfg  (cfg_r),
    .req  (s1_r),
    .calc (calc)
  );

  hvps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s2_adv),
    .cfg   (cfg_r),
    .calc  (s2_r),
    .res   (res)
  );

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (out_rdy) out_v_r <= s2_v_r;
    end
  end

  // Pipeline payload; hold when stalled
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) s1_r <= in_req;
    if (s2_rdy && s1_v_r) s2_r <= calc;
    if (s2_adv) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

`ifndef SYNTH
  // Input backs up only when the result side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_v_r && out_stall))
    else $error("in_stall without downstream stall");

  // A latched drop fault forces the safe stage with both relays open
  a_fault_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.contactor_fault) |->
      (out_r.stage_code == hvps_pkg::STG_SAFETY && !out_r.main_on && !out_r.precharge_on))
    else $error("fault result not in safe state");

  // Done stage means main closed and precharge open
  a_done_relays: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.stage_code == hvps_pkg::STG_DONE) |->
      (out_r.main_on && !out_r.precharge_on))
    else $error("done stage with wrong relay state");

  // A taken result leaves the output register when no new result follows it
  a_result_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_stall && !s2_v_r) |=> !out_v_r)
    else $error("result repeated");
`endif

endmodule
